// ===== rtl/sawg_pkg.sv =====
// Shared types, constants and the arctangent table of the arc waypoint generator.
package sawg_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int COORD_BITS   = 32;
	localparam int SPEED_BITS   = 32;
	localparam int RADIUS_BITS  = COORD_BITS - 1;
	localparam int COUNT_BITS   = 5;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W     = 64;
	localparam int CORDIC_ZW    = 34;
	localparam int CORDIC_PRE   = 58 - COORD_BITS;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int DIV_W        = 41;
	localparam int DIV_DEN_W    = COUNT_BITS + 2;

	localparam logic [31:0] CORDIC_GAIN = 32'h26DD_3B6A;
	localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] THREE_QUARTER_TURN = ANGLE_BITS'(3 * QUARTER_TURN);
	localparam logic [ANGLE_BITS:0] ANGLE_NUM_STEP = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BASE,
		ST_BASE_W,
		ST_NEXT,
		ST_DIVA,
		ST_DIVA_W,
		ST_ROT,
		ST_ROT_W,
		ST_MULX,
		ST_ADDX,
		ST_MULY,
		ST_ADDY,
		ST_WHEEL,
		ST_WHEEL_W,
		ST_EMIT,
		ST_GOAL
	} state_t;

	typedef struct packed {
		logic start;
		logic vec;
	} cordic_cmd_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h2000_0000;
			5'd1:  v = 32'h12E4_051E;
			5'd2:  v = 32'h09FB_385B;
			5'd3:  v = 32'h0511_11D4;
			5'd4:  v = 32'h028B_0D43;
			5'd5:  v = 32'h0145_D7E1;
			5'd6:  v = 32'h00A2_F61E;
			5'd7:  v = 32'h0051_7C55;
			5'd8:  v = 32'h0028_BE53;
			5'd9:  v = 32'h0014_5F2F;
			5'd10: v = 32'h000A_2F98;
			5'd11: v = 32'h0005_17CC;
			5'd12: v = 32'h0002_8BE6;
			5'd13: v = 32'h0001_45F3;
			5'd14: v = 32'h0000_A2FA;
			5'd15: v = 32'h0000_517D;
			5'd16: v = 32'h0000_28BE;
			5'd17: v = 32'h0000_145F;
			5'd18: v = 32'h0000_0A30;
			5'd19: v = 32'h0000_0518;
			5'd20: v = 32'h0000_028C;
			5'd21: v = 32'h0000_0146;
			5'd22: v = 32'h0000_00A3;
			5'd23: v = 32'h0000_0051;
			5'd24: v = 32'h0000_0029;
			5'd25: v = 32'h0000_0014;
			5'd26: v = 32'h0000_000A;
			5'd27: v = 32'h0000_0005;
			5'd28: v = 32'h0000_0003;
			5'd29: v = 32'h0000_0001;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/semicircle_arc_waypoint_generator.sv =====
// Top level of the semicircle arc waypoint generator: sequencer and datapath registers.
//
// One arc request enters on the s_axis channel as a single word. The block then
// produces points_between intermediate waypoints on the semicircle between start
// and goal, followed by the goal waypoint marked with tlast, on the m_axis channel.
// points_between is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. A request is
// taken only while the block is idle, and s_axis_tready stays low until the goal
// word has been taken. Each waypoint is worked out with one shared CORDIC (30
// steps) and one bit-serial divider (40 steps). A bearing along an axis skips the
// CORDIC steps. The result word is held in a register; while the receiver stalls
// the word and tvalid are held and the sequencer waits.
// After reset the block is idle, points_between is 4, and no result is pending.
module semicircle_arc_waypoint_generator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [4:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// start_x, start_y, start_speed, goal_x, goal_y, goal_speed, arc_radius, zero pad
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// point_x, point_y, heading, wheel_angle, point_speed
	output logic [127:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam int CB = sawg_pkg::COORD_BITS;
	localparam int SB = sawg_pkg::SPEED_BITS;
	localparam int AB = sawg_pkg::ANGLE_BITS;
	localparam int NB = sawg_pkg::COUNT_BITS;
	localparam int DB = sawg_pkg::DIFF_BITS;
	localparam int QW = sawg_pkg::DIV_W;
	localparam int PW = sawg_pkg::RADIUS_BITS + 32;
	localparam int RW = PW - 30 + 2;
	localparam int SW = RW + 1;

	sawg_pkg::state_t state_q, state_d;
	sawg_pkg::cordic_cmd_t cmd;

	logic [NB-1:0] cfg_n_q;
	logic [NB-1:0] n_q;
	logic [NB-1:0] pt_q;

	logic signed [CB-1:0] gx_q, gy_q, cx_q, cy_q, sx_q, sy_q, px_q, py_q;
	logic signed [SB-1:0] sv_q, gv_q, v_q;
	logic [sawg_pkg::RADIUS_BITS-1:0] r_q;
	logic signed [DB-1:0] dv_q;
	logic [AB+NB:0] ang_num_full_q;
	logic signed [QW-1:0] spd_num_q;
	logic [AB-1:0] base_q, a_q;
	logic [PW-1:0] prod_q;
	logic          pneg_q;

	logic [CB-1:0] o_x_q, o_y_q;
	logic [AB-1:0] o_head_q, o_wheel_q;
	logic [SB-1:0] o_v_q;
	logic          o_last_q;

	logic                 div_start;
	logic signed [QW-1:0] div_num;
	logic                 div_busy;
	logic signed [QW-1:0] div_quo;
	logic                 cor_busy;
	logic [AB-1:0]        cor_ang;
	logic signed [31:0]   cor_cos, cor_sin;
	logic signed [DB-1:0] cor_dy, cor_dx;

	logic                 accept;
	logic [NB:0]          d_ext;
	logic signed [CB:0]   sum_cx, sum_cy;
	logic signed [31:0]   csel;
	logic [31:0]          cmag;
	logic [PW-1:0]        prod_rnd;
	logic [RW-1:0]        res_mag;
	logic signed [SW-1:0] res_s;
	logic signed [SW-1:0] csum;
	logic signed [CB-1:0] csat;
	logic signed [CB-1:0] cbase;
	logic [AB-1:0]        head;

	function automatic logic [NB:0] d_ext_q(input logic [NB-1:0] n);
		return {1'b0, n} + 1'b1;
	endfunction

	assign accept = s_axis_tvalid && s_axis_tready;
	assign d_ext  = {1'b0, cfg_n_q} + 1'b1;
	assign sum_cx = $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
		+ $signed({s_axis_tdata[127], s_axis_tdata[127:96]});
	assign sum_cy = $signed({s_axis_tdata[63], s_axis_tdata[63:32]})
		+ $signed({s_axis_tdata[159], s_axis_tdata[159:128]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sawg_pkg::ST_IDLE;
			cfg_n_q <= 5'd4;
			pt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_n_q <= cfg_wdata;
			end
			if (accept) begin
				pt_q <= '0;
			end else if (state_q == sawg_pkg::ST_NEXT) begin
				pt_q <= pt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.vec   = 1'b1;
		div_start = 1'b0;
		div_num   = $signed(QW'(ang_num_full_q));
		case (state_q)
			sawg_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = sawg_pkg::ST_BASE;
				end
			end
			sawg_pkg::ST_BASE: begin
				cmd.start = 1'b1;
				state_d   = sawg_pkg::ST_BASE_W;
			end
			sawg_pkg::ST_BASE_W: begin
				if (!cor_busy) begin
					state_d = (n_q == '0) ? sawg_pkg::ST_GOAL : sawg_pkg::ST_NEXT;
				end
			end
			sawg_pkg::ST_NEXT: begin
				state_d = sawg_pkg::ST_DIVA;
			end
			sawg_pkg::ST_DIVA: begin
				div_start = 1'b1;
				state_d   = sawg_pkg::ST_DIVA_W;
			end
			sawg_pkg::ST_DIVA_W: begin
				if (!div_busy) begin
					state_d = sawg_pkg::ST_ROT;
				end
			end
			sawg_pkg::ST_ROT: begin
				cmd.start = 1'b1;
				cmd.vec   = 1'b0;
				div_start = 1'b1;
				div_num   = spd_num_q;
				state_d   = sawg_pkg::ST_ROT_W;
			end
			sawg_pkg::ST_ROT_W: begin
				if (!cor_busy && !div_busy) begin
					state_d = sawg_pkg::ST_MULX;
				end
			end
			sawg_pkg::ST_MULX:  state_d = sawg_pkg::ST_ADDX;
			sawg_pkg::ST_ADDX:  state_d = sawg_pkg::ST_MULY;
			sawg_pkg::ST_MULY:  state_d = sawg_pkg::ST_ADDY;
			sawg_pkg::ST_ADDY:  state_d = sawg_pkg::ST_WHEEL;
			sawg_pkg::ST_WHEEL: begin
				cmd.start = 1'b1;
				state_d   = sawg_pkg::ST_WHEEL_W;
			end
			sawg_pkg::ST_WHEEL_W: begin
				if (!cor_busy) begin
					state_d = sawg_pkg::ST_EMIT;
				end
			end
			sawg_pkg::ST_EMIT: begin
				if (m_axis_tready) begin
					if (o_last_q) begin
						state_d = sawg_pkg::ST_IDLE;
					end else if (pt_q == n_q) begin
						state_d = sawg_pkg::ST_GOAL;
					end else begin
						state_d = sawg_pkg::ST_NEXT;
					end
				end
			end
			sawg_pkg::ST_GOAL: begin
				state_d = sawg_pkg::ST_EMIT;
			end
			default: state_d = sawg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		if (state_q == sawg_pkg::ST_BASE) begin
			cor_dy = DB'(sy_q) - DB'(gy_q);
			cor_dx = DB'(sx_q) - DB'(gx_q);
		end else begin
			cor_dy = DB'(gy_q) - DB'(py_q);
			cor_dx = DB'(gx_q) - DB'(px_q);
		end
		csel     = (state_q == sawg_pkg::ST_MULX) ? cor_cos : cor_sin;
		cmag     = csel[31] ? 32'(-csel) : 32'(csel);
		prod_rnd = prod_q + (PW'(1) << 29);
		res_mag  = {2'b00, prod_rnd[PW-1:30]};
		res_s    = pneg_q ? $signed(-{1'b0, res_mag}) : $signed({1'b0, res_mag});
		cbase    = (state_q == sawg_pkg::ST_ADDX) ? cx_q : cy_q;
		csum     = SW'(cbase) + res_s;
		if (csum > $signed(SW'({1'b0, {(CB-1){1'b1}}}))) begin
			csat = $signed({1'b0, {(CB-1){1'b1}}});
		end else if (csum < $signed(-SW'({1'b0, {(CB-1){1'b1}}}) - SW'(1))) begin
			csat = $signed({1'b1, {(CB-1){1'b0}}});
		end else begin
			csat = csum[CB-1:0];
		end
		head = a_q + sawg_pkg::QUARTER_TURN;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q      <= s_axis_tdata[31:0];
			sy_q      <= s_axis_tdata[63:32];
			sv_q      <= s_axis_tdata[95:64];
			gx_q      <= s_axis_tdata[127:96];
			gy_q      <= s_axis_tdata[159:128];
			gv_q      <= s_axis_tdata[191:160];
			r_q       <= s_axis_tdata[222:192];
			cx_q      <= sum_cx[CB:1];
			cy_q      <= sum_cy[CB:1];
			dv_q      <= DB'($signed(s_axis_tdata[191:160])) - DB'($signed(s_axis_tdata[95:64]));
			n_q       <= cfg_n_q;
			ang_num_full_q <= (AB + NB + 1)'(d_ext);
			spd_num_q <= $signed(QW'(d_ext));
		end
		case (state_q)
			sawg_pkg::ST_BASE_W: begin
				base_q <= cor_ang;
			end
			sawg_pkg::ST_NEXT: begin
				ang_num_full_q <= ang_num_full_q + (AB + NB + 1)'(sawg_pkg::ANGLE_NUM_STEP);
				spd_num_q <= spd_num_q + (QW'(dv_q) <<< 1);
			end
			sawg_pkg::ST_DIVA_W: begin
				a_q <= base_q + div_quo[AB-1:0];
			end
			sawg_pkg::ST_ROT_W: begin
				v_q <= sv_q + div_quo[SB-1:0];
			end
			sawg_pkg::ST_MULX, sawg_pkg::ST_MULY: begin
				prod_q <= PW'(r_q) * PW'(cmag);
				pneg_q <= csel[31];
			end
			sawg_pkg::ST_ADDX: px_q <= csat;
			sawg_pkg::ST_ADDY: py_q <= csat;
			sawg_pkg::ST_WHEEL_W: begin
				o_x_q     <= px_q;
				o_y_q     <= py_q;
				o_head_q  <= head;
				o_wheel_q <= cor_ang - head;
				o_v_q     <= v_q;
				o_last_q  <= 1'b0;
			end
			sawg_pkg::ST_GOAL: begin
				o_x_q     <= gx_q;
				o_y_q     <= gy_q;
				o_head_q  <= base_q + sawg_pkg::THREE_QUARTER_TURN;
				o_wheel_q <= '0;
				o_v_q     <= gv_q;
				o_last_q  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	sawg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.dy      (cor_dy),
		.dx      (cor_dx),
		.ang     (a_q),
		.busy    (cor_busy),
		.ang_out (cor_ang),
		.cos_out (cor_cos),
		.sin_out (cor_sin)
	);

	sawg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    ({d_ext_q(n_q), 1'b0}),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign s_axis_tready = (state_q == sawg_pkg::ST_IDLE);
	assign m_axis_tvalid = (state_q == sawg_pkg::ST_EMIT);
	assign m_axis_tdata  = {o_v_q, o_wheel_q, o_head_q, o_y_q, o_x_q};
	assign m_axis_tlast  = o_last_q;

	a_start_base: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == sawg_pkg::ST_BASE)
		else $error("request accepted but bearing not started");

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sawg_pkg::ST_IDLE |-> !cor_busy && !div_busy)
		else $error("arithmetic unit busy while idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sawg_pkg::ST_IDLE |-> pt_q <= n_q)
		else $error("waypoint count beyond configured count");

	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> pt_q == n_q)
		else $error("goal word sent before all waypoints");

endmodule

// ===== rtl/sawg_div.sv =====
// Bit-serial floor divider of a signed numerator by a small positive divisor.
module sawg_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [sawg_pkg::DIV_W-1:0]     num,
	input  logic        [sawg_pkg::DIV_DEN_W-1:0] den,
	output logic                                  busy,
	output logic signed [sawg_pkg::DIV_W-1:0]     quo
);

	localparam int MW = sawg_pkg::DIV_W - 1;
	localparam int DW = sawg_pkg::DIV_DEN_W;
	localparam int CW = $clog2(MW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] mag_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          take;
	logic [sawg_pkg::DIV_W-1:0] abs_num;
	logic [sawg_pkg::DIV_W-1:0] qext;

	always_comb begin
		trial   = {rem_q, mag_q[MW-1]};
		diff    = trial - {1'b0, den_q};
		take    = (trial >= {1'b0, den_q});
		abs_num = num[sawg_pkg::DIV_W-1] ? -num : num;
		qext    = {1'b0, mag_q} + {{(sawg_pkg::DIV_W-1){1'b0}}, (rem_q != '0)};
		quo     = neg_q ? $signed(-qext) : $signed({1'b0, mag_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(MW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= abs_num[MW-1:0];
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[sawg_pkg::DIV_W-1];
		end else if (busy_q) begin
			mag_q <= {mag_q[MW-2:0], take};
			rem_q <= take ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign busy = busy_q;

endmodule

// ===== rtl/sawg_cordic.sv =====
// Shared iterative CORDIC for the bearing (vectoring) and the sine and cosine (rotation).
module sawg_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sawg_pkg::cordic_cmd_t                  cmd,
	input  logic signed [sawg_pkg::DIFF_BITS-1:0]  dy,
	input  logic signed [sawg_pkg::DIFF_BITS-1:0]  dx,
	input  logic        [sawg_pkg::ANGLE_BITS-1:0] ang,
	output logic                                   busy,
	output logic        [sawg_pkg::ANGLE_BITS-1:0] ang_out,
	output logic signed [31:0]                     cos_out,
	output logic signed [31:0]                     sin_out
);

	localparam int W  = sawg_pkg::CORDIC_W;
	localparam int ZW = sawg_pkg::CORDIC_ZW;
	localparam int AB = sawg_pkg::ANGLE_BITS;

	logic                 busy_q;
	logic [4:0]           cnt_q;
	logic signed [W-1:0]  x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic                 vec_q, flip_q;

	logic [31:0]          a32, a32s, a32f;
	logic                 flip;
	logic                 axis;
	logic [31:0]          z_axis;
	logic signed [W-1:0]  dx_w, dy_w;
	logic                 dpos;
	logic signed [W-1:0]  xs, ys;
	logic signed [ZW-1:0] at;
	logic [31:0]          zr;
	logic [31:0]          xl, yl;

	always_comb begin
		a32  = {ang, {(32 - AB){1'b0}}};
		a32s = a32 + 32'h4000_0000;
		flip = a32s[31];
		a32f = flip ? (a32 ^ 32'h8000_0000) : a32;
		axis = (dy == '0) || (dx == '0);
		if (dy == '0) begin
			z_axis = dx[sawg_pkg::DIFF_BITS-1] ? 32'h8000_0000 : 32'h0000_0000;
		end else begin
			z_axis = dy[sawg_pkg::DIFF_BITS-1] ? 32'hC000_0000 : 32'h4000_0000;
		end
		dx_w = W'(dx) <<< sawg_pkg::CORDIC_PRE;
		dy_w = W'(dy) <<< sawg_pkg::CORDIC_PRE;
		dpos = vec_q ? y_q[W-1] : !z_q[ZW-1];
		xs   = x_q >>> cnt_q;
		ys   = y_q >>> cnt_q;
		at   = $signed({{(ZW - 32){1'b0}}, sawg_pkg::atan_entry(cnt_q)});
		zr   = z_q[31:0] + (32'h1 << (31 - AB));
		xl   = x_q[31:0];
		yl   = y_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= !(cmd.vec && axis);
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'(sawg_pkg::CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			vec_q <= cmd.vec;
			if (cmd.vec) begin
				flip_q <= 1'b0;
				if (axis) begin
					x_q <= '0;
					y_q <= '0;
					z_q <= $signed({{(ZW - 32){1'b0}}, z_axis});
				end else if (dx_w[W-1]) begin
					x_q <= -dx_w;
					y_q <= -dy_w;
					z_q <= $signed({{(ZW - 32){1'b0}}, 32'h8000_0000});
				end else begin
					x_q <= dx_w;
					y_q <= dy_w;
					z_q <= '0;
				end
			end else begin
				flip_q <= flip;
				x_q    <= $signed({{(W - 32){1'b0}}, sawg_pkg::CORDIC_GAIN});
				y_q    <= '0;
				z_q    <= $signed({{(ZW - 32){a32f[31]}}, a32f});
			end
		end else if (busy_q) begin
			if (dpos) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy    = busy_q;
	assign ang_out = zr[31:32-AB];
	assign cos_out = flip_q ? $signed(-xl) : $signed(xl);
	assign sin_out = flip_q ? $signed(-yl) : $signed(yl);

endmodule

// ===== tb/tb_semicircle_arc_waypoint_generator.sv =====
// Self-checking testbench for the semicircle arc waypoint generator.
`timescale 1ns / 1ps

module tb_semicircle_arc_waypoint_generator;

	localparam int LIMIT_CYCLES = 10_000_000;
	localparam int SETTLE_CYCLES = 300;

	localparam bit [31:0] ARC_TAB [30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef struct {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_speed;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic signed [31:0] goal_speed;
		logic [30:0]        arc_radius;
	} arc_request_t;

	typedef struct {
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [15:0] heading;
		logic [15:0] wheel_angle;
		logic [31:0] point_speed;
		logic        last;
	} waypoint_t;

	class waypoint_scoreboard;
		waypoint_t pending[$];
		logic [4:0] points_between = 5'd4;
		int errors = 0;

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
		endtask

		function bit [15:0] bearing(longint dy, longint dx);
			bit [31:0] z;
			longint x, y, t;
			z = 0;
			if (dy == 0)
				z = dx >= 0 ? 32'h0 : 32'h80000000;
			else if (dx == 0)
				z = dy > 0 ? 32'h40000000 : 32'hC0000000;
			else begin
				x = dx * 67108864;
				y = dy * 67108864;
				if (x < 0) begin
					x = -x;
					y = -y;
					z = 32'h80000000;
				end
				for (int i = 0; i < 30; i++) begin
					if (y < 0) begin
						t = x - (y >>> i);
						y = y + (x >>> i);
						z = z - ARC_TAB[i];
					end else begin
						t = x + (y >>> i);
						y = y - (x >>> i);
						z = z + ARC_TAB[i];
					end
					x = t;
				end
			end
			return 16'(({1'b0, z} + 33'd32768) >> 16);
		endfunction

		function void sin_cos(bit [15:0] ang, output longint c, output longint s);
			bit [31:0] a, tmp;
			bit flip;
			longint x, y, z, t;
			a = {ang, 16'h0};
			tmp = a + 32'h40000000;
			flip = tmp[31];
			if (flip)
				a = a + 32'h80000000;
			z = longint'($signed(a));
			x = 652032874;
			y = 0;
			for (int i = 0; i < 30; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z = z - longint'(ARC_TAB[i]);
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z = z + longint'(ARC_TAB[i]);
				end
				x = t;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint radius_product(longint unsigned r, longint c);
			longint unsigned mag, a, lo;
			longint res;
			mag = c < 0 ? longint'(-c) : longint'(c);
			a = (r >> 24) * mag;
			lo = (r & 64'hFFFFFF) * mag + (64'd1 << 29);
			res = longint'((a >> 6) + ((((a & 64'd63) << 24) + lo) >> 30));
			return c < 0 ? -res : res;
		endfunction

		function longint floor_div(longint num, longint den);
			longint q;
			q = num / den;
			if (num % den != 0 && num < 0)
				q--;
			return q;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function void note_request(arc_request_t rq);
			longint sx, sy, sv, gx, gy, gv, dv, cx, cy, c, s, px, py, v, d;
			longint unsigned r;
			bit [15:0] base, a, head;
			longint off;
			waypoint_t w;
			sx = rq.start_x; sy = rq.start_y; sv = rq.start_speed;
			gx = rq.goal_x; gy = rq.goal_y; gv = rq.goal_speed;
			r = rq.arc_radius;
			dv = gv - sv;
			d = longint'(points_between) + 1;
			cx = (sx + gx) >>> 1;
			cy = (sy + gy) >>> 1;
			base = bearing(sy - gy, sx - gx);
			for (longint i = 1; i < d; i++) begin
				off = (i * 65536 + d) / (2 * d);
				a = base + 16'(off);
				sin_cos(a, c, s);
				px = clamp32(cx + radius_product(r, c));
				py = clamp32(cy + radius_product(r, s));
				head = a + sawg_pkg::QUARTER_TURN;
				v = sv + floor_div(dv * 2 * i + d, 2 * d);
				w.point_x = px[31:0];
				w.point_y = py[31:0];
				w.heading = head;
				w.wheel_angle = bearing(gy - py, gx - px) - head;
				w.point_speed = v[31:0];
				w.last = 1'b0;
				pending.push_back(w);
			end
			w.point_x = rq.goal_x;
			w.point_y = rq.goal_y;
			w.heading = base + sawg_pkg::THREE_QUARTER_TURN;
			w.wheel_angle = 16'h0;
			w.point_speed = rq.goal_speed;
			w.last = 1'b1;
			pending.push_back(w);
		endfunction

		task check_waypoint(logic [127:0] word, logic last);
			waypoint_t e;
			if (pending.size() == 0) begin
				report("unexpected word", word[31:0], 32'h0);
				return;
			end
			e = pending.pop_front();
			if (word[31:0] !== e.point_x) report("point_x", word[31:0], e.point_x);
			if (word[63:32] !== e.point_y) report("point_y", word[63:32], e.point_y);
			if (word[79:64] !== e.heading) report("heading", word[79:64], e.heading);
			if (word[95:80] !== e.wheel_angle)
				report("wheel_angle", word[95:80], e.wheel_angle);
			if (word[127:96] !== e.point_speed)
				report("point_speed", word[127:96], e.point_speed);
			if (last !== e.last) report("last", last, e.last);
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [4:0]   cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tlast;

	semicircle_arc_waypoint_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	waypoint_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_waypoint(m_axis_tdata, m_axis_tlast);
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_request(arc_request_t rq);
		@(posedge clk);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, rq.arc_radius, rq.goal_speed, rq.goal_y, rq.goal_x,
			rq.start_speed, rq.start_y, rq.start_x};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_request(rq);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_fields(logic [31:0] sx, logic [31:0] sy, logic [31:0] sv,
		logic [31:0] gx, logic [31:0] gy, logic [31:0] gv, logic [30:0] r);
		arc_request_t rq;
		rq = '{sx, sy, sv, gx, gy, gv, r};
		send_request(rq);
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_points(logic [4:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.points_between = value;
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return 32'($urandom_range(65535) - 32768) <<< 8;
		endcase
	endfunction

	task automatic send_random();
		arc_request_t rq;
		rq.start_x = random_coord();
		rq.start_y = random_coord();
		rq.goal_x = $urandom_range(9) == 0 ? rq.start_x : random_coord();
		rq.goal_y = $urandom_range(9) == 0 ? rq.start_y : random_coord();
		rq.start_speed = $urandom_range(1) ? $urandom : 32'($urandom_range(655360));
		rq.goal_speed = $urandom_range(1) ? $urandom : 32'($urandom_range(655360));
		case ($urandom_range(3))
			0: rq.arc_radius = 31'($urandom);
			1: rq.arc_radius = 31'($urandom_range(1000) << 16);
			2: rq.arc_radius = 31'($urandom_range(65535));
			default: rq.arc_radius = 31'(($urandom_range(1) ? rq.goal_x - rq.start_x
				: rq.goal_y - rq.start_y) >>> 1);
		endcase
		send_request(rq);
	endtask

	initial begin
		@(posedge arst_n);
		// Edge cases at the reset setting of four points between.
		send_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF);
		send_fields(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
		send_fields(32'h00010000, 32'h00020000, 32'h00010000,
			32'h00010000, 32'h00020000, 32'h00030000, 31'h00010000);
		send_fields(32'h00050000, 32'h00000000, 32'h0, 32'h00050000, 32'h000A0000,
			32'h00040000, 31'h00050000);
		send_fields(32'h00050000, 32'h000A0000, 32'h0, 32'h00050000, 32'h00000000,
			32'h00040000, 31'h00050000);
		send_fields(32'h00000000, 32'h00030000, 32'hFFFF0000, 32'h000A0000,
			32'h00030000, 32'h00010000, 31'h00050000);
		send_fields(32'h000A0000, 32'h00030000, 32'h0, 32'h00000000, 32'h00030000,
			32'h0, 31'h00050000);
		send_fields(32'h00000000, 32'h00000000, 32'h0, 32'h00000000, 32'h00000000,
			32'h0, 31'h0);
		send_fields(32'h00100000, 32'hFFF00000, 32'h00010000, 32'hFFF00000,
			32'h00100000, 32'h00010001, 31'h0);
		send_fields(32'h7FFF0000, 32'h7FFF0000, 32'h0, 32'h7FFF0000, 32'h7FF00000,
			32'h0, 31'h7FFFFFFF);
		send_fields(32'h80000000, 32'h80010000, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h80000000, 31'h40000000);
		send_fields(32'h00030000, 32'h00040000, 32'h0, 32'hFFFD0000, 32'hFFFC0000,
			32'h0, 31'h00050000);
		send_fields(32'hFFFFFFFF, 32'h00000001, 32'h0, 32'h00000001, 32'hFFFFFFFF,
			32'h00000003, 31'h1);
		write_points(5'd0);
		send_fields(32'h00010000, 32'h00010000, 32'h00020000, 32'h00040000,
			32'h00050000, 32'h00060000, 31'h00028000);
		send_fields(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 31'h0);
		write_points(5'd31);
		send_fields(32'hFFF60000, 32'h00000000, 32'h0, 32'h000A0000, 32'h00000000,
			32'h001F0000, 31'h000A0000);
		send_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF);

		// No idling, no intermediate points.
		write_points(5'd0);
		repeat (60) send_random();

		// Sender idle, longest arcs.
		write_points(5'd31);
		send_idle_pct = 45;
		repeat (25) send_random();

		// Receiver stalling, then a long hold-off while requests keep coming.
		write_points(5'd3);
		send_idle_pct = 0;
		recv_stall_pct = 45;
		repeat (40) send_random();
		hold_off = 3000;
		repeat (40) send_random();

		// Both sides idle now and then.
		write_points(5'd1);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		repeat (60) send_random();

		// Mixed settings with no idling, then sixteen points between with both sides idle now and then.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int k = 0; k < 6; k++) begin
			write_points(5'($urandom_range(10)));
			repeat (15) send_random();
		end
		write_points(5'd16);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		repeat (20) send_random();

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
